>>> rtl/core/bba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bba_pkg: shared types and constants of the block bitmap allocator
// Item structs, status codes and the command/status groups that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int DEF_MAX_BLOCKS = 4096;
  localparam int FIELD_SPAN     = 4096;
  localparam int BLK_W          = 12;
  localparam int CNT_W          = 13;
  localparam int STS_W          = 2;
  localparam int WORD_W         = 32;
  localparam int BIT_W          = 5;

  localparam logic [CNT_W-1:0] TOTAL_RESET = 13'd4096;

  localparam logic [STS_W-1:0] ST_OK          = 2'd0;
  localparam logic [STS_W-1:0] ST_FULL        = 2'd1;
  localparam logic [STS_W-1:0] ST_DOUBLE_FREE = 2'd2;
  localparam logic [STS_W-1:0] ST_RANGE       = 2'd3;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [BLK_W-1:0] block_number;
  } in_t;

  typedef struct packed {
    logic [BLK_W-1:0] granted_block;
    logic [STS_W-1:0] status;
  } out_t;

  typedef struct packed {
    logic             capture;
    logic             rd_free;
    logic             rd_scan_start;
    logic             scan_adv;
    logic             wr_alloc;
    logic             wr_free;
    logic             clr_wr;
    logic             emit;
    logic [STS_W-1:0] emit_status;
  } cmd_t;

  typedef struct packed {
    logic req_free;
    logic count_zero;
    logic blk_range;
    logic found;
    logic last_word;
    logic bit_set;
    logic clr_done;
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/core/bba_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bba_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire  [$clog2(DEPTH)-1:0]  waddr,
  input  wire  [WIDTH-1:0]          wdata,
  input  wire  [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/core/bba_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bba_datapath: bitmap memory, scan pointer and result register
// Holds the block count register, walks the bitmap one word per cycle and
// finds the lowest clear bit of the word under check.
// ----------------------------------------------------------------------------
module bba_datapath #(
  parameter int MAX_BLOCKS = bba_pkg::DEF_MAX_BLOCKS
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  bba_pkg::in_t                   in_data,
  input  wire                            cfg_valid,
  input  wire  [bba_pkg::CNT_W-1:0]      cfg_data,
  input  bba_pkg::cmd_t                  cmd,
  output bba_pkg::sts_t                  sts,
  output bba_pkg::out_t                  out_data
);

  localparam int EFF   = (MAX_BLOCKS < bba_pkg::FIELD_SPAN) ? MAX_BLOCKS
                                                            : bba_pkg::FIELD_SPAN;
  localparam int WORDS = (EFF + bba_pkg::WORD_W - 1) / bba_pkg::WORD_W;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int DEPTH = 1 << AW;

  localparam logic [bba_pkg::CNT_W-1:0] EFF_CNT = bba_pkg::CNT_W'(EFF);

  logic [bba_pkg::CNT_W-1:0]  total_blocks_r;
  logic [bba_pkg::CNT_W-1:0]  total_blocks_nxt;
  logic [AW-1:0]              chk_addr_r;
  logic [AW-1:0]              chk_addr_nxt;
  logic [AW-1:0]              clr_addr_r;
  logic [AW-1:0]              clr_addr_nxt;
  logic [bba_pkg::BLK_W-1:0]  req_blk_r;
  logic [bba_pkg::BLK_W-1:0]  req_blk_nxt;
  bba_pkg::out_t              out_data_r;
  bba_pkg::out_t              out_data_nxt;

  logic [bba_pkg::CNT_W-1:0]  count_eff;
  logic [bba_pkg::CNT_W-1:0]  base;
  logic [bba_pkg::CNT_W-1:0]  rem;
  logic [AW-1:0]              last_idx;
  logic [bba_pkg::WORD_W-1:0] rd_data;
  logic [bba_pkg::WORD_W-1:0] mask;
  logic [bba_pkg::WORD_W-1:0] free_bits;
  logic [bba_pkg::WORD_W-1:0] iso;
  logic [bba_pkg::BIT_W-1:0]  idx;
  logic [bba_pkg::BLK_W-1:0]  grant;

  logic                       we;
  logic [AW-1:0]              waddr;
  logic [bba_pkg::WORD_W-1:0] wdata;
  logic [AW-1:0]              raddr;

  bba_ram #(
    .WIDTH (bba_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_data)
  );

  assign count_eff = (total_blocks_r > EFF_CNT) ? EFF_CNT : total_blocks_r;
  assign last_idx  = AW'((count_eff - 13'd1) >> bba_pkg::BIT_W);
  assign base      = bba_pkg::CNT_W'(chk_addr_r) << bba_pkg::BIT_W;
  assign rem       = count_eff - base;

  // bits of the checked word that lie below the block count
  assign mask      = (rem >= 13'd32) ? '1 : ((32'd1 << rem[bba_pkg::BIT_W-1:0]) - 32'd1);
  assign free_bits = ~rd_data & mask;
  assign iso       = free_bits & (~free_bits + 32'd1);

  always_comb begin
    idx = '0;
    for (int j = 0; j < bba_pkg::WORD_W; j++) begin
      if (iso[j]) begin
        idx = idx | bba_pkg::BIT_W'(j);
      end
    end
  end

  assign grant = (bba_pkg::BLK_W'(chk_addr_r) << bba_pkg::BIT_W) | bba_pkg::BLK_W'(idx);

  always_comb begin
    we    = 1'b0;
    waddr = chk_addr_r;
    wdata = rd_data | iso;
    if (cmd.clr_wr) begin
      we    = 1'b1;
      waddr = clr_addr_r;
      wdata = '0;
    end else if (cmd.wr_alloc) begin
      we    = 1'b1;
    end else if (cmd.wr_free) begin
      we    = 1'b1;
      waddr = AW'(req_blk_r >> bba_pkg::BIT_W);
      wdata = rd_data & ~(32'd1 << req_blk_r[bba_pkg::BIT_W-1:0]);
    end
  end

  always_comb begin
    raddr = chk_addr_r + 1'b1;
    if (cmd.rd_free) begin
      raddr = AW'(in_data.block_number >> bba_pkg::BIT_W);
    end else if (cmd.rd_scan_start) begin
      raddr = '0;
    end
  end

  always_comb begin
    total_blocks_nxt = cfg_valid ? cfg_data : total_blocks_r;
    clr_addr_nxt     = cmd.clr_wr ? clr_addr_r + 1'b1 : clr_addr_r;
    req_blk_nxt      = cmd.capture ? in_data.block_number : req_blk_r;
    chk_addr_nxt     = chk_addr_r;
    if (cmd.rd_scan_start) begin
      chk_addr_nxt = '0;
    end else if (cmd.scan_adv) begin
      chk_addr_nxt = chk_addr_r + 1'b1;
    end
    out_data_nxt = out_data_r;
    if (cmd.emit) begin
      out_data_nxt.granted_block = cmd.wr_alloc ? grant : '0;
      out_data_nxt.status        = cmd.emit_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_blocks_r <= bba_pkg::TOTAL_RESET;
      clr_addr_r     <= '0;
    end else begin
      total_blocks_r <= total_blocks_nxt;
      clr_addr_r     <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_addr_r <= chk_addr_nxt;
    req_blk_r  <= req_blk_nxt;
    out_data_r <= out_data_nxt;
  end

  assign sts.req_free   = (in_data.req_type == bba_pkg::REQ_FREE);
  assign sts.count_zero = (count_eff == '0);
  assign sts.blk_range  = ({1'b0, in_data.block_number} >= count_eff);
  assign sts.found      = |free_bits;
  assign sts.last_word  = (chk_addr_r == last_idx);
  assign sts.bit_set    = rd_data[req_blk_r[bba_pkg::BIT_W-1:0]];
  assign sts.clr_done   = (clr_addr_r == AW'(DEPTH - 1));

  assign out_data = out_data_r;

endmodule
`default_nettype wire

>>> rtl/core/bba_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bba_ctrl: allocator sequencer
// Runs the bitmap clearing pass, then takes one request at a time through
// the scan or free sequence and raises the result strobe.
// ----------------------------------------------------------------------------
module bba_ctrl (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           start,
  input  bba_pkg::sts_t sts,
  output logic          busy,
  output logic          out_valid,
  output bba_pkg::cmd_t cmd
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_FREE  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          if (sts.req_free) begin
            if (sts.blk_range) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = bba_pkg::ST_RANGE;
            end else begin
              cmd.rd_free = 1'b1;
              state_nxt   = S_FREE;
            end
          end else if (sts.count_zero) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = bba_pkg::ST_FULL;
          end else begin
            cmd.rd_scan_start = 1'b1;
            state_nxt         = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (sts.found) begin
          cmd.wr_alloc    = 1'b1;
          cmd.emit        = 1'b1;
          cmd.emit_status = bba_pkg::ST_OK;
          state_nxt       = S_IDLE;
        end else if (sts.last_word) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = bba_pkg::ST_FULL;
          state_nxt       = S_IDLE;
        end else begin
          cmd.scan_adv = 1'b1;
        end
      end
      S_FREE: begin
        cmd.emit = 1'b1;
        if (sts.bit_set) begin
          cmd.wr_free     = 1'b1;
          cmd.emit_status = bba_pkg::ST_OK;
        end else begin
          cmd.emit_status = bba_pkg::ST_DOUBLE_FREE;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.emit;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // every accepted item either keeps the block busy or answers next cycle
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted item neither in progress nor answered");

  // no result may come out of the clearing pass
  a_no_result_from_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) != S_CLEAR))
    else $error("result strobe after clearing pass cycle");

  // a clear bit found during a scan ends the item with a grant
  a_found_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && sts.found) |=> (state_r == S_IDLE && out_valid))
    else $error("scan did not finish on a found block");

endmodule
`default_nettype wire

>>> rtl/core/block_bitmap_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// block_bitmap_allocator: first-fit block allocator over an in-use bitmap
// Allocates the lowest free block below the block count, or frees a block.
// ----------------------------------------------------------------------------
// Usage:
//   in_data is taken when start is high and busy is low. req_type selects an
//   allocate or a free of block_number. Each item gives exactly one result,
//   shown on out_data for one cycle with out_valid high; the receiver cannot
//   stall it.
//   A free of a block below the block count reads its bitmap word on
//   acceptance and answers once that word has been checked in the free state.
//   An allocate scans the bitmap memory one 32-bit word per cycle with the
//   read data registered, from word 0 up to the word holding the granted
//   block or the last word below the block count. A rejected free and an
//   allocate with a zero block count answer on the cycle after acceptance.
//   The cfg channel writes the block count; it is always ready and is to be
//   written only while no item is in flight.
//   After reset the bitmap memory is cleared one word per cycle, over the
//   word count rounded up to a power of two, while busy stays high; the
//   block count returns to 4096.
// ----------------------------------------------------------------------------
module block_bitmap_allocator #(
  parameter int MAX_BLOCKS = bba_pkg::DEF_MAX_BLOCKS
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start,
  output logic                       busy,
  input  bba_pkg::in_t               in_data,
  output logic                       out_valid,
  output bba_pkg::out_t              out_data,
  input  wire                        cfg_valid,
  output logic                       cfg_ready,
  input  wire  [bba_pkg::CNT_W-1:0]  cfg_data
);

  bba_pkg::cmd_t cmd;
  bba_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  bba_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

>>> verif/block_bitmap_allocator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_bitmap_allocator_test: self-checking bench for the block allocator
// Drives allocate and free items through the start/busy port in random bursts,
// rewrites the block count between phases while the block is idle, and checks
// every result against an in-bench first-fit model of the in-use bitmap.
// ----------------------------------------------------------------------------
module block_bitmap_allocator_test;
  import bba_pkg::*;

  localparam int MAX_BLK       = DEF_MAX_BLOCKS;
  localparam int RANDOM_ITEMS  = 500;
  localparam int IDLE_LIMIT    = 2000;
  localparam int DRAIN_CYCLES  = 140;

  typedef struct {
    bit               is_count;
    logic [CNT_W-1:0] count_value;
    in_t              item;
  } stim_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             start     = 1'b0;
  logic             busy;
  in_t              in_data   = '0;
  logic             out_valid;
  out_t             out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data  = '0;

  // model state: one bit per block plus the managed block count
  bit               block_taken [0:MAX_BLK-1];
  logic [CNT_W-1:0] managed_blocks = TOTAL_RESET;

  stim_t stimulus [$];
  out_t  pending_results [$];

  int errors       = 0;
  int items_taken  = 0;
  int count_writes = 0;
  int status_seen [4];
  int burst_left   = 1;
  int gap_left     = 0;
  int idle_cycles  = 0;

  always #1 clk = ~clk;

  block_bitmap_allocator #(
    .MAX_BLOCKS(MAX_BLK)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // count actually in force: clamped to the map size and the block field span
  function automatic int usable_blocks(logic [CNT_W-1:0] count);
    int lim;
    lim = int'(count);
    if (lim > MAX_BLK) lim = MAX_BLK;
    if (lim > FIELD_SPAN) lim = FIELD_SPAN;
    return lim;
  endfunction

  function automatic out_t apply_request(in_t req);
    out_t res;
    int   lim;
    int   b;
    lim = usable_blocks(managed_blocks);
    res.granted_block = '0;
    if (req.req_type == REQ_ALLOC) begin
      res.status = ST_FULL;
      for (b = 0; b < lim; b++) begin
        if (!block_taken[b]) begin
          block_taken[b]    = 1'b1;
          res.granted_block = BLK_W'(b);
          res.status        = ST_OK;
          break;
        end
      end
    end else if (req.block_number >= lim) begin
      res.status = ST_RANGE;
    end else if (!block_taken[req.block_number]) begin
      res.status = ST_DOUBLE_FREE;
    end else begin
      block_taken[req.block_number] = 1'b0;
      res.status = ST_OK;
    end
    return res;
  endfunction

  task automatic queue_item(logic req, logic [BLK_W-1:0] blk);
    stim_t s;
    s.is_count           = 1'b0;
    s.count_value        = '0;
    s.item.req_type      = req;
    s.item.block_number  = blk;
    stimulus.push_back(s);
  endtask

  task automatic queue_count(logic [CNT_W-1:0] value);
    stim_t s;
    s.is_count    = 1'b1;
    s.count_value = value;
    s.item        = '0;
    stimulus.push_back(s);
  endtask

  task automatic wait_drained();
    while (stimulus.size() != 0 || pending_results.size() != 0 || start || cfg_valid)
      @(posedge clk);
  endtask

  // driver: holds start until taken, count writes only when nothing is in flight
  always @(posedge clk) begin : drive
    logic  nxt_start;
    logic  nxt_cfg;
    stim_t s;
    if (!rst_n) begin
      start     <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      nxt_start = start;
      nxt_cfg   = cfg_valid;
      if (start && !busy) begin
        pending_results.push_back(apply_request(in_data));
        items_taken++;
        nxt_start = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        managed_blocks = cfg_data;
        count_writes++;
        nxt_cfg = 1'b0;
      end
      if (!nxt_start && !nxt_cfg) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (stimulus.size() > 0) begin
          if (stimulus[0].is_count) begin
            // out_valid high means a result is being taken at this edge
            if (!start && !cfg_valid && !busy && !out_valid && pending_results.size() == 0) begin
              s = stimulus.pop_front();
              cfg_data <= s.count_value;
              nxt_cfg = 1'b1;
            end
          end else begin
            s = stimulus.pop_front();
            in_data <= s.item;
            nxt_start = 1'b1;
            if (burst_left > 1) begin
              burst_left--;
            end else begin
              burst_left = $urandom_range(1, 16);
              gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
          end
        end
      end
      start     <= nxt_start;
      cfg_valid <= nxt_cfg;
    end
  end

  always @(posedge clk) begin : monitor
    out_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing outstanding: granted %0d status %0d",
                 $time, out_data.granted_block, out_data.status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.granted_block !== want.granted_block) begin
          $display("%0t: granted_block mismatch: expected %0d, got %0d",
                   $time, want.granted_block, out_data.granted_block);
          errors++;
        end
        if (out_data.status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, got %0d",
                   $time, want.status, out_data.status);
          errors++;
        end
        status_seen[want.status]++;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("** block_bitmap_allocator: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus_gen
    int               queued;
    int               phase_len;
    int               alloc_pct;
    int               lim;
    int               b;
    int               pick;
    logic [CNT_W-1:0] new_count;
    int               taken_list [$];

    for (b = 0; b < MAX_BLK; b++) block_taken[b] = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset count, both extremes of block_number, empty count,
    // clamping of an oversized count, filling up, and shrinking the count
    queue_item(REQ_FREE, 12'd0);
    queue_item(REQ_FREE, 12'hFFF);
    queue_item(REQ_ALLOC, 12'hFFF);
    queue_item(REQ_ALLOC, 12'd0);
    queue_item(REQ_FREE, 12'd0);
    queue_item(REQ_ALLOC, 12'h555);
    queue_count(13'd0);
    queue_item(REQ_ALLOC, 12'd0);
    queue_item(REQ_FREE, 12'd0);
    queue_count(13'h1FFF);
    queue_item(REQ_FREE, 12'hFFF);
    queue_item(REQ_ALLOC, 12'hAAA);
    queue_count(13'd3);
    queue_item(REQ_ALLOC, 12'd7);
    queue_item(REQ_FREE, 12'd3);
    queue_item(REQ_FREE, 12'd2);
    queue_item(REQ_ALLOC, 12'd0);
    queue_count(13'd1);
    queue_item(REQ_FREE, 12'd2);
    queue_item(REQ_ALLOC, 12'd1);
    queue_count(13'd4096);
    queue_item(REQ_FREE, 12'd2);
    queue_item(REQ_FREE, 12'd1);
    queue_item(REQ_ALLOC, 12'd0);

    queued = 0;
    while (queued < RANDOM_ITEMS) begin
      wait_drained();
      pick = $urandom_range(0, 19);
      if (pick < 2)       new_count = 13'd0;
      else if (pick < 4)  new_count = 13'd1;
      else if (pick < 6)  new_count = 13'd4096;
      else if (pick == 6) new_count = 13'h1FFF;
      else if (pick < 9)  new_count = CNT_W'($urandom_range(0, 8191));
      else                new_count = CNT_W'($urandom_range(2, 64));
      queue_count(new_count);

      // blocks in use below the new count make likely targets for a free
      lim = usable_blocks(new_count);
      taken_list.delete();
      for (b = 0; b < lim; b++)
        if (block_taken[b]) taken_list.push_back(b);

      phase_len = $urandom_range(15, 40);
      alloc_pct = $urandom_range(15, 85);
      repeat (phase_len) begin
        if ($urandom_range(0, 99) < alloc_pct) begin
          queue_item(REQ_ALLOC, BLK_W'($urandom_range(0, 4095)));
        end else begin
          pick = $urandom_range(0, 9);
          if (pick < 5 && taken_list.size() > 0)
            queue_item(REQ_FREE,
                       BLK_W'(taken_list[$urandom_range(0, taken_list.size() - 1)]));
          else if (pick < 8)
            queue_item(REQ_FREE,
                       BLK_W'($urandom_range(0, (lim + 3 > 4095) ? 4095 : lim + 3)));
          else
            queue_item(REQ_FREE, BLK_W'($urandom_range(0, 4095)));
        end
        queued++;
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      errors++;
    end

    $display("ran %0d items over %0d block count writes", items_taken, count_writes);
    $display("ok %0d, out of blocks %0d, freeing a free block %0d, out of range %0d",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_DOUBLE_FREE],
             status_seen[ST_RANGE]);
    if (errors == 0)
      $display("** block_bitmap_allocator: PASSED **");
    else
      $display("** block_bitmap_allocator: FAILED **");
    $finish;
  end

endmodule
